FILE: rtl/core/mhpq_pkg.sv
// shared types and constants for the max-heap priority queue
`default_nettype none

package mhpq_pkg;

   localparam int VALUE_W = 32;
   localparam int COUNT_W = 11;

   localparam logic signed [VALUE_W-1:0] MOST_NEGATIVE = {1'b1, {(VALUE_W-1){1'b0}}};

   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_POP    = 2'd1;
   localparam logic [1:0] OP_PEEK   = 2'd2;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   typedef struct packed {
      logic [1:0]                operation;
      logic signed [VALUE_W-1:0] value;
   } req_word_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] top_value;
      logic                      is_empty;
      logic [COUNT_W-1:0]        entry_count;
      logic [1:0]                status;
   } rsp_word_type;

endpackage

`default_nettype wire

FILE: rtl/core/max_heap_priority_queue_core.sv
// binary max-heap priority queue: sequencer, shared comparator and entry memory
//
//   channel | direction | ports                     | word
//   --------+-----------+---------------------------+-----------------------------
//   request | in        | req_valid req_stall       | operation, value
//   response| out       | rsp_valid rsp_stall       | top_value, is_empty, count, status
//
// one word at a time: req_stall is high from acceptance until the response is loaded
// peek and rejected ops go straight to the response; insert climbs one level per
// parent compare, pop moves the last entry to the root and descends one level per
// child compare; each step is paced by the single read port and the one comparator
// reset is synchronous; it empties the heap, the memory itself is not cleared
// a new word is accepted while the previous response still waits on rsp_stall
`default_nettype none

module max_heap_priority_queue_core
   import mhpq_pkg::*;
#(
   parameter int CAPACITY = 1024
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire req_word_type req_word,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output rsp_word_type      rsp_word
);

   localparam int IW  = $clog2(CAPACITY);
   localparam int CW  = $clog2(CAPACITY + 1);
   localparam int CIW = IW + 2;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_UP_CHK = 4'd1;
   localparam logic [3:0] S_UP_CMP = 4'd2;
   localparam logic [3:0] S_POP_RD = 4'd3;
   localparam logic [3:0] S_POP_LD = 4'd4;
   localparam logic [3:0] S_DN_RDL = 4'd5;
   localparam logic [3:0] S_DN_RDR = 4'd6;
   localparam logic [3:0] S_DN_CMP = 4'd7;
   localparam logic [3:0] S_FIN    = 4'd8;

   logic [3:0]                state_ff, state_in;
   logic [CW-1:0]             count_ff, count_in;
   logic [IW-1:0]             pos_ff, pos_in;
   logic signed [VALUE_W-1:0] cur_ff, cur_in;
   logic signed [VALUE_W-1:0] best_val_ff, best_val_in;
   logic                      best_left_ff, best_left_in;
   logic signed [VALUE_W-1:0] top_ff, top_in;
   logic [1:0]                status_ff, status_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_word_type              rsp_word_ff, rsp_word_in;

   logic                      wr_en;
   logic [IW-1:0]             wr_addr;
   logic signed [VALUE_W-1:0] wr_data;
   logic [IW-1:0]             rd_addr;
   logic signed [VALUE_W-1:0] rd_data;

   logic signed [VALUE_W-1:0] cmp_a, cmp_b;
   logic                      cmp_gt;

   logic [IW-1:0]  parent_idx;
   logic [CIW-1:0] lchild_idx, rchild_idx, count_ext;
   logic           left_ok, right_ok;
   logic           req_accept;

   mhpq_store #(
      .DEPTH (CAPACITY),
      .IDX_W (IW)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign cmp_gt = cmp_a > cmp_b;

   assign parent_idx = (pos_ff - IW'(1)) >> 1;
   assign lchild_idx = {1'b0, pos_ff, 1'b1};
   assign rchild_idx = lchild_idx + CIW'(1);
   assign count_ext  = CIW'(count_ff);
   assign left_ok    = lchild_idx < count_ext;
   assign right_ok   = rchild_idx < count_ext;

   assign req_stall  = state_ff != S_IDLE;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      pos_in       = pos_ff;
      cur_in       = cur_ff;
      best_val_in  = best_val_ff;
      best_left_in = best_left_ff;
      status_in    = status_ff;
      rsp_word_in  = rsp_word_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      wr_en        = 1'b0;
      wr_addr      = pos_ff;
      wr_data      = cur_ff;
      rd_addr      = pos_ff;
      cmp_a        = cur_ff;
      cmp_b        = rd_data;

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               status_in = STATUS_OK;
               state_in  = S_FIN;
               case (req_word.operation)
                  OP_INSERT: begin
                     if (count_ff >= CW'(CAPACITY)) begin
                        status_in = STATUS_FULL;
                     end else begin
                        cur_in   = req_word.value;
                        pos_in   = IW'(count_ff);
                        count_in = count_ff + CW'(1);
                        state_in = S_UP_CHK;
                     end
                  end
                  OP_POP: begin
                     if (count_ff == '0) begin
                        status_in = STATUS_EMPTY;
                     end else begin
                        count_in = count_ff - CW'(1);
                        pos_in   = '0;
                        state_in = S_POP_RD;
                     end
                  end
                  default: begin
                     status_in = STATUS_OK;
                  end
               endcase
            end
         end
         S_UP_CHK: begin
            if (pos_ff == '0) begin
               wr_en    = 1'b1;
               state_in = S_FIN;
            end else begin
               rd_addr  = parent_idx;
               state_in = S_UP_CMP;
            end
         end
         S_UP_CMP: begin
            wr_en = 1'b1;
            if (cmp_gt) begin
               wr_data  = rd_data;
               pos_in   = parent_idx;
               state_in = S_UP_CHK;
            end else begin
               state_in = S_FIN;
            end
         end
         S_POP_RD: begin
            rd_addr  = IW'(count_ff);
            state_in = S_POP_LD;
         end
         S_POP_LD: begin
            cur_in   = rd_data;
            state_in = S_DN_RDL;
         end
         S_DN_RDL: begin
            if (!left_ok) begin
               wr_en    = 1'b1;
               state_in = S_FIN;
            end else begin
               rd_addr  = lchild_idx[IW-1:0];
               state_in = S_DN_RDR;
            end
         end
         S_DN_RDR: begin
            if (right_ok) begin
               rd_addr = rchild_idx[IW-1:0];
            end
            cmp_a        = rd_data;
            cmp_b        = cur_ff;
            best_left_in = cmp_gt;
            best_val_in  = cmp_gt ? rd_data : cur_ff;
            state_in     = S_DN_CMP;
         end
         S_DN_CMP: begin
            cmp_a = rd_data;
            cmp_b = best_val_ff;
            wr_en = 1'b1;
            if (right_ok && cmp_gt) begin
               wr_data  = rd_data;
               pos_in   = rchild_idx[IW-1:0];
               state_in = S_DN_RDL;
            end else if (best_left_ff) begin
               wr_data  = best_val_ff;
               pos_in   = lchild_idx[IW-1:0];
               state_in = S_DN_RDL;
            end else begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_word_in.top_value   = (count_ff == '0) ? MOST_NEGATIVE : top_ff;
               rsp_word_in.is_empty    = count_ff == '0;
               rsp_word_in.entry_count = COUNT_W'(count_ff);
               rsp_word_in.status      = status_ff;
               rsp_valid_in            = 1'b1;
               state_in                = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign top_in = (wr_en && wr_addr == '0) ? wr_data : top_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pos_ff       <= pos_in;
      cur_ff       <= cur_in;
      best_val_ff  <= best_val_in;
      best_left_ff <= best_left_in;
      top_ff       <= top_in;
      status_ff    <= status_in;
      rsp_word_ff  <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

`default_nettype wire

FILE: rtl/core/mhpq_store.sv
// heap entry memory, one write and one registered read per cycle
`default_nettype none

module mhpq_store
   import mhpq_pkg::*;
#(
   parameter int DEPTH = 1024,
   parameter int IDX_W = 10
) (
   input  wire logic                      clock,
   input  wire logic                      wr_en,
   input  wire logic [IDX_W-1:0]          wr_addr,
   input  wire logic signed [VALUE_W-1:0] wr_data,
   input  wire logic [IDX_W-1:0]          rd_addr,
   output logic signed [VALUE_W-1:0]      rd_data
);

   logic signed [VALUE_W-1:0] mem [DEPTH];
   logic signed [VALUE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire
